// ----- src/fpsm_pkg.sv -----
// ============================================================================
// fpsm_pkg: shared types and constants
// Page and digit geometry, operation codes, sequencer states and the request
// struct that the sequencer sends to the summary store.
// ============================================================================
`default_nettype none

package fpsm_pkg;

    localparam int PAGE_W     = 16;
    localparam int DIGIT_BITS = 4;
    localparam int LEVELS     = 4;
    localparam int FANOUT     = 1 << DIGIT_BITS;
    localparam int LVL_W      = $clog2(LEVELS);
    localparam int SH_W       = $clog2(PAGE_W);
    localparam int KIND_W     = 3;

    // Row index widths of the upper, lower and leaf levels
    localparam int UP_W = DIGIT_BITS;
    localparam int LO_W = 2 * DIGIT_BITS;
    localparam int LF_W = 3 * DIGIT_BITS;

    localparam logic [LVL_W-1:0] LVL_TOP   = LVL_W'(0);
    localparam logic [LVL_W-1:0] LVL_UPPER = LVL_W'(1);
    localparam logic [LVL_W-1:0] LVL_LOWER = LVL_W'(2);
    localparam logic [LVL_W-1:0] LVL_LEAF  = LVL_W'(LEVELS - 1);

    localparam logic [KIND_W-1:0] KIND_INSERT = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_DELETE = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_LOOKUP = KIND_W'(2);
    localparam logic [KIND_W-1:0] KIND_PEEK   = KIND_W'(3);
    localparam logic [KIND_W-1:0] KIND_POP    = KIND_W'(4);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        MODE_INSERT,
        MODE_DELETE,
        MODE_LOOKUP,
        MODE_FIND
    } mode_t;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [LVL_W-1:0]  lvl;
        logic [PAGE_W-1:0] path;
        logic [FANOUT-1:0] wdata;
    } mem_req_t;

    // Bit offset of the digit that selects a bit at the given level
    function automatic logic [SH_W-1:0] digit_shift(input logic [LVL_W-1:0] lvl);
        return SH_W'(DIGIT_BITS * (LEVELS - 1 - int'(lvl)));
    endfunction

endpackage

`default_nettype wire

// ----- src/fpsm_level_unit.sv -----
// ============================================================================
// fpsm_level_unit: shared word unit
// Sets, clears and tests one bit of a summary word and finds its lowest
// set bit; reused at every level of the walk.
// ============================================================================
`default_nettype none

module fpsm_level_unit (
    input  wire logic [fpsm_pkg::FANOUT-1:0]     word,
    input  wire logic [fpsm_pkg::DIGIT_BITS-1:0] digit,
    output logic      [fpsm_pkg::FANOUT-1:0]     set_word,
    output logic      [fpsm_pkg::FANOUT-1:0]     clr_word,
    output logic                                 bit_hit,
    output logic                                 word_zero,
    output logic                                 clr_zero,
    output logic      [fpsm_pkg::DIGIT_BITS-1:0] low_idx
);

    logic [fpsm_pkg::FANOUT-1:0] mask;

    assign mask      = fpsm_pkg::FANOUT'(1) << digit;
    assign set_word  = word | mask;
    assign clr_word  = word & ~mask;
    assign bit_hit   = |(word & mask);
    assign word_zero = (word == '0);
    assign clr_zero  = (clr_word == '0);

    // Lowest set bit; an empty word gives the top index
    always_comb
    begin
        low_idx = fpsm_pkg::DIGIT_BITS'(fpsm_pkg::FANOUT - 1);
        for (int i = fpsm_pkg::FANOUT - 1; i >= 0; i--)
        begin
            if (word[i])
            begin
                low_idx = fpsm_pkg::DIGIT_BITS'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/fpsm_store.sv -----
// ============================================================================
// fpsm_store: summary and leaf storage
// Top and upper summaries in flops, lower summaries and leaf words in
// memories with registered reads; sweeps both memories to zero after reset.
// ============================================================================
`default_nettype none

module fpsm_store (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire fpsm_pkg::mem_req_t          req,
    output logic [fpsm_pkg::FANOUT-1:0]      rd_word,
    output logic                             top_zero,
    output logic                             clr_busy
);

    localparam int LO_DEPTH = 1 << fpsm_pkg::LO_W;
    localparam int LF_DEPTH = 1 << fpsm_pkg::LF_W;

    logic [fpsm_pkg::FANOUT-1:0] top_reg;
    logic [fpsm_pkg::FANOUT-1:0] upper_reg [fpsm_pkg::FANOUT];
    logic [fpsm_pkg::FANOUT-1:0] lower_mem [LO_DEPTH];
    logic [fpsm_pkg::FANOUT-1:0] leaf_mem  [LF_DEPTH];

    logic [fpsm_pkg::FANOUT-1:0] small_q_reg;
    logic [fpsm_pkg::FANOUT-1:0] lower_q_reg;
    logic [fpsm_pkg::FANOUT-1:0] leaf_q_reg;
    logic [fpsm_pkg::LVL_W-1:0]  rd_lvl_reg;

    logic                        clr_busy_reg;
    logic [fpsm_pkg::LF_W-1:0]   clr_cnt_reg;

    logic [fpsm_pkg::UP_W-1:0]   up_idx;
    logic [fpsm_pkg::LO_W-1:0]   lo_idx;
    logic [fpsm_pkg::LF_W-1:0]   lf_idx;

    assign up_idx = req.path[fpsm_pkg::PAGE_W-1 -: fpsm_pkg::UP_W];
    assign lo_idx = req.path[fpsm_pkg::PAGE_W-1 -: fpsm_pkg::LO_W];
    assign lf_idx = req.path[fpsm_pkg::PAGE_W-1 -: fpsm_pkg::LF_W];

    assign top_zero = (top_reg == '0);
    assign clr_busy = clr_busy_reg;

    // Clearing sweep over the leaf rows; lower rows ride along on the low counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + fpsm_pkg::LF_W'(1);
            if (clr_cnt_reg == '1)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= '0;
            for (int i = 0; i < fpsm_pkg::FANOUT; i++)
            begin
                upper_reg[i] <= '0;
            end
        end
        else if (req.wr_en)
        begin
            if (req.lvl == fpsm_pkg::LVL_TOP)
            begin
                top_reg <= req.wdata;
            end
            if (req.lvl == fpsm_pkg::LVL_UPPER)
            begin
                upper_reg[up_idx] <= req.wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            if (clr_cnt_reg[fpsm_pkg::LF_W-1:fpsm_pkg::LO_W] == '0)
            begin
                lower_mem[clr_cnt_reg[fpsm_pkg::LO_W-1:0]] <= '0;
            end
        end
        else if (req.wr_en && req.lvl == fpsm_pkg::LVL_LOWER)
        begin
            lower_mem[lo_idx] <= req.wdata;
        end
        if (req.rd_en)
        begin
            lower_q_reg <= lower_mem[lo_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            leaf_mem[clr_cnt_reg] <= '0;
        end
        else if (req.wr_en && req.lvl == fpsm_pkg::LVL_LEAF)
        begin
            leaf_mem[lf_idx] <= req.wdata;
        end
        if (req.rd_en)
        begin
            leaf_q_reg <= leaf_mem[lf_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_lvl_reg  <= req.lvl;
            small_q_reg <= (req.lvl == fpsm_pkg::LVL_TOP) ? top_reg : upper_reg[up_idx];
        end
    end

    always_comb
    begin
        unique case (rd_lvl_reg)
            fpsm_pkg::LVL_LOWER: rd_word = lower_q_reg;
            fpsm_pkg::LVL_LEAF:  rd_word = leaf_q_reg;
            default:             rd_word = small_q_reg;
        endcase
    end

endmodule

`default_nettype wire

// ----- src/free_page_set_min_finder.sv -----
// ============================================================================
// free_page_set_min_finder: free page set with smallest-page search
// Hierarchical bitmap of free 16-bit pages (four levels of 16-way summaries)
// walked one level at a time by a small sequencer around one word unit.
// ============================================================================
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  in      | into      | in_valid / in_stall  | kind, page
//  out     | out of    | out_valid / out_stall| min_page, hit, set_empty
//
// Each level visit is a read of the level's word, then an evaluate step in
// the shared word unit (with its write-back). Insert and peek visit every
// level from the top down, lookup only the leaf; delete climbs from the leaf
// until a word stays nonzero or the top is done, and pop does as peek, then
// deletes. A peek or pop on an empty set visits only the top, a request on
// page 0 or with a spare kind none. After reset the block sweeps the leaf and
// lower-summary memories to zero with in_stall high.
// A finished result sits in the output register; a new request is taken
// while it waits. A request is held in the done step only while an earlier
// result is still stalled.
// ============================================================================
`default_nettype none

module free_page_set_min_finder (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [fpsm_pkg::KIND_W-1:0]   kind,
    input  wire logic [fpsm_pkg::PAGE_W-1:0]   page,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [fpsm_pkg::PAGE_W-1:0]   min_page,
    output logic                               hit,
    output logic                               set_empty
);

    fpsm_pkg::state_t             state_reg, state_next;
    fpsm_pkg::mode_t              mode_reg, mode_next;
    logic                         pop_reg, pop_next;
    logic [fpsm_pkg::LVL_W-1:0]   lvl_reg, lvl_next;
    logic [fpsm_pkg::PAGE_W-1:0]  path_reg, path_next;
    logic [fpsm_pkg::PAGE_W-1:0]  min_reg, min_next;
    logic                         hit_reg, hit_next;

    logic                         out_valid_reg;
    logic [fpsm_pkg::PAGE_W-1:0]  out_min_reg;
    logic                         out_hit_reg;
    logic                         out_empty_reg;

    fpsm_pkg::mem_req_t           req;
    logic [fpsm_pkg::FANOUT-1:0]  rd_word;
    logic                         top_zero;
    logic                         clr_busy;

    logic [fpsm_pkg::SH_W-1:0]    shift;
    logic [fpsm_pkg::DIGIT_BITS-1:0] digit;
    logic [fpsm_pkg::FANOUT-1:0]  set_word;
    logic [fpsm_pkg::FANOUT-1:0]  clr_word;
    logic                         bit_hit;
    logic                         word_zero;
    logic                         clr_zero;
    logic [fpsm_pkg::DIGIT_BITS-1:0] low_idx;
    logic [fpsm_pkg::PAGE_W-1:0]  path_found;

    logic                         in_fire;
    logic                         out_load;
    logic                         start_walk;
    logic                         walk_end;

    // ------------------------------------------------------------------
    // Storage and the shared word unit
    // ------------------------------------------------------------------
    fpsm_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rd_word  (rd_word),
        .top_zero (top_zero),
        .clr_busy (clr_busy)
    );

    assign shift = fpsm_pkg::digit_shift(lvl_reg);
    assign digit = path_reg[shift +: fpsm_pkg::DIGIT_BITS];

    fpsm_level_unit u_unit (
        .word      (rd_word),
        .digit     (digit),
        .set_word  (set_word),
        .clr_word  (clr_word),
        .bit_hit   (bit_hit),
        .word_zero (word_zero),
        .clr_zero  (clr_zero),
        .low_idx   (low_idx)
    );

    // Path with this level's digit replaced by the lowest set bit
    always_comb
    begin
        path_found = path_reg;
        path_found[shift +: fpsm_pkg::DIGIT_BITS] = low_idx;
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign in_stall = (state_reg != fpsm_pkg::ST_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_load = (state_reg == fpsm_pkg::ST_DONE) && (!out_valid_reg || !out_stall);

    // Page 0 never enters the store, so those requests finish at once
    always_comb
    begin
        start_walk = 1'b0;
        unique case (kind)
            fpsm_pkg::KIND_INSERT,
            fpsm_pkg::KIND_DELETE,
            fpsm_pkg::KIND_LOOKUP: start_walk = (page != '0);
            fpsm_pkg::KIND_PEEK,
            fpsm_pkg::KIND_POP:    start_walk = 1'b1;
            default:               start_walk = 1'b0;
        endcase
    end

    // Walk ends: insert and lookup at the leaf, delete once a word stays nonzero
    // or at the top, find on an empty set or at the leaf unless a pop follows
    always_comb
    begin
        unique case (mode_reg)
            fpsm_pkg::MODE_INSERT: walk_end = (lvl_reg == fpsm_pkg::LVL_LEAF);
            fpsm_pkg::MODE_DELETE: walk_end = !clr_zero || (lvl_reg == fpsm_pkg::LVL_TOP);
            fpsm_pkg::MODE_LOOKUP: walk_end = 1'b1;
            fpsm_pkg::MODE_FIND:   walk_end = ((lvl_reg == fpsm_pkg::LVL_TOP) && word_zero)
                                           || ((lvl_reg == fpsm_pkg::LVL_LEAF) && !pop_reg);
            default:               walk_end = 1'b1;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fpsm_pkg::ST_CLEAR:
            begin
                if (!clr_busy)
                begin
                    state_next = fpsm_pkg::ST_IDLE;
                end
            end
            fpsm_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = start_walk ? fpsm_pkg::ST_READ : fpsm_pkg::ST_DONE;
                end
            end
            fpsm_pkg::ST_READ:
            begin
                state_next = fpsm_pkg::ST_EVAL;
            end
            fpsm_pkg::ST_EVAL:
            begin
                state_next = walk_end ? fpsm_pkg::ST_DONE : fpsm_pkg::ST_READ;
            end
            fpsm_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = fpsm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fpsm_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: datapath and store requests
    // ------------------------------------------------------------------
    always_comb
    begin
        mode_next = mode_reg;
        pop_next  = pop_reg;
        lvl_next  = lvl_reg;
        path_next = path_reg;
        min_next  = min_reg;
        hit_next  = hit_reg;

        req.rd_en = 1'b0;
        req.wr_en = 1'b0;
        req.lvl   = lvl_reg;
        req.path  = path_reg;
        req.wdata = set_word;

        unique case (state_reg)
            fpsm_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    // Latch the request and pick the walk direction
                    path_next = page;
                    min_next  = '0;
                    hit_next  = 1'b0;
                    pop_next  = (kind == fpsm_pkg::KIND_POP);
                    unique case (kind)
                        fpsm_pkg::KIND_INSERT:
                        begin
                            mode_next = fpsm_pkg::MODE_INSERT;
                            lvl_next  = fpsm_pkg::LVL_TOP;
                        end
                        fpsm_pkg::KIND_DELETE:
                        begin
                            mode_next = fpsm_pkg::MODE_DELETE;
                            lvl_next  = fpsm_pkg::LVL_LEAF;
                        end
                        fpsm_pkg::KIND_LOOKUP:
                        begin
                            mode_next = fpsm_pkg::MODE_LOOKUP;
                            lvl_next  = fpsm_pkg::LVL_LEAF;
                        end
                        fpsm_pkg::KIND_PEEK,
                        fpsm_pkg::KIND_POP:
                        begin
                            mode_next = fpsm_pkg::MODE_FIND;
                            lvl_next  = fpsm_pkg::LVL_TOP;
                        end
                        default:
                        begin
                            mode_next = mode_reg;
                        end
                    endcase
                end
            end
            fpsm_pkg::ST_READ:
            begin
                req.rd_en = 1'b1;
            end
            fpsm_pkg::ST_EVAL:
            begin
                unique case (mode_reg)
                    fpsm_pkg::MODE_INSERT:
                    begin
                        req.wr_en = 1'b1;
                        req.wdata = set_word;
                        if (!walk_end)
                        begin
                            lvl_next = lvl_reg + fpsm_pkg::LVL_W'(1);
                        end
                    end
                    fpsm_pkg::MODE_DELETE:
                    begin
                        req.wr_en = 1'b1;
                        req.wdata = clr_word;
                        if (!walk_end)
                        begin
                            lvl_next = lvl_reg - fpsm_pkg::LVL_W'(1);
                        end
                    end
                    fpsm_pkg::MODE_LOOKUP:
                    begin
                        hit_next = bit_hit;
                    end
                    fpsm_pkg::MODE_FIND:
                    begin
                        if (!((lvl_reg == fpsm_pkg::LVL_TOP) && word_zero))
                        begin
                            path_next = path_found;
                            if (lvl_reg == fpsm_pkg::LVL_LEAF)
                            begin
                                // Minimum found; a pop turns around and deletes it
                                min_next  = path_found;
                                hit_next  = 1'b1;
                                mode_next = fpsm_pkg::MODE_DELETE;
                            end
                            else
                            begin
                                lvl_next = lvl_reg + fpsm_pkg::LVL_W'(1);
                            end
                        end
                    end
                    default:
                    begin
                        hit_next = hit_reg;
                    end
                endcase
            end
            default:
            begin
                hit_next = hit_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fpsm_pkg::ST_CLEAR;
            mode_reg  <= fpsm_pkg::MODE_LOOKUP;
            pop_reg   <= 1'b0;
            lvl_reg   <= fpsm_pkg::LVL_TOP;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            pop_reg   <= pop_next;
            lvl_reg   <= lvl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        path_reg <= path_next;
        min_reg  <= min_next;
        hit_reg  <= hit_next;
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_min_reg   <= min_reg;
            out_hit_reg   <= hit_reg;
            out_empty_reg <= top_zero;
        end
    end

    assign out_valid = out_valid_reg;
    assign min_page  = out_min_reg;
    assign hit       = out_hit_reg;
    assign set_empty = out_empty_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fpsm_pkg::ST_EVAL |-> $past(state_reg) == fpsm_pkg::ST_READ)
        else $error("evaluate step without a preceding read");

    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> in_stall)
        else $error("request taken during the clearing sweep");

    a_min_implies_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (min_page != '0) |-> hit)
        else $error("nonzero minimum without hit");

    a_empty_matches_top: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> set_empty == top_zero)
        else $error("empty flag disagrees with top summary");

endmodule

`default_nettype wire
